>>> src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> src/ttd_pkg.sv
`timescale 1ns / 1ps
package ttd_pkg;
    typedef enum logic [2:0] {
        FMT_I4 = 3'd0, FMT_I8 = 3'd1, FMT_IA4 = 3'd2, FMT_IA8 = 3'd3,
        FMT_RGB565 = 3'd4, FMT_RGB5A3 = 3'd5, FMT_RGBA8 = 3'd6, FMT_CMPR = 3'd7
    } t_fmt;

    typedef enum logic [1:0] {
        REG_FMT = 2'd0, REG_WIDTH = 2'd1, REG_HEIGHT = 2'd2
    } t_reg;

    // Classified item handed from front to back
    typedef struct packed {
        t_fmt        fmt;
        logic [7:0]  data;
        logic [7:0]  held;
        logic [5:0]  boff;
        logic [12:0] bx;
        logic [12:0] by;
        logic        done;
    } t_item;

    // 5-bit to 8-bit widening
    // floor(v*255/max) through a reciprocal multiply, exact over the input range
    function automatic logic [7:0] sc5(input logic [4:0] v);
        logic [26:0] t;
        t = 27'(v) * 27'd255 * 27'd8457;
        sc5 = 8'(t >> 18);
    endfunction
    function automatic logic [7:0] sc6(input logic [5:0] v);
        logic [28:0] t;
        t = 29'(v) * 29'd255 * 29'd16645;
        sc6 = 8'(t >> 20);
    endfunction
    function automatic logic [7:0] sc4(input logic [3:0] v);
        sc4 = {v, v};
    endfunction
    function automatic logic [7:0] sc3(input logic [2:0] v);
        logic [24:0] t;
        t = 25'(v) * 25'd255 * 25'd9363;
        sc3 = 8'(t >> 16);
    endfunction
endpackage

>>> src/ttd_front.sv
`timescale 1ns / 1ps
module ttd_front import ttd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);
    logic [2:0]  r_fmt;
    logic [10:0] r_w, r_h;
    logic [9:0]  r_tcol, r_trow;
    logic [5:0]  r_boff;
    logic [7:0]  r_held;
    logic [10:0] n_tcol, n_trow;
    logic [12:0] w_c, h_c;
    logic [10:0] tiles_x, tiles_y;
    logic [5:0]  boff, tlast;
    logic        acc, tile_end, row_end, img_end, wide_x, tall_y;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_full;
    assign acc         = i_valid && !i_full;

    // Clamp dimensions
    always_comb begin
        if (r_w == '0) w_c = 13'd1;
        else if ({2'b0, r_w} > 13'(MAX_WIDTH)) w_c = 13'(MAX_WIDTH);
        else w_c = {2'b0, r_w};
        if (r_h == '0) h_c = 13'd1;
        else if ({2'b0, r_h} > 13'(MAX_HEIGHT)) h_c = 13'(MAX_HEIGHT);
        else h_c = {2'b0, r_h};
    end

    assign wide_x  = (r_fmt == FMT_I4 || r_fmt == FMT_I8 || r_fmt == FMT_IA4
                      || r_fmt == FMT_CMPR);
    assign tall_y  = (r_fmt == FMT_I4 || r_fmt == FMT_CMPR);
    assign tiles_x = wide_x ? 11'((w_c + 13'd7) >> 3) : 11'((w_c + 13'd3) >> 2);
    assign tiles_y = tall_y ? 11'((h_c + 13'd7) >> 3) : 11'((h_c + 13'd3) >> 2);
    assign tlast   = (r_fmt == FMT_RGBA8) ? 6'd63 : 6'd31;
    assign boff    = (r_fmt != FMT_RGBA8 && r_boff[5]) ? 6'd0 : r_boff;
    assign tile_end = (boff == tlast);
    assign n_tcol  = {1'b0, r_tcol} + 11'd1;
    assign n_trow  = {1'b0, r_trow} + 11'd1;
    assign row_end = n_tcol >= tiles_x;
    assign img_end = tile_end && row_end && (n_trow >= tiles_y);

    // Classify item
    always_comb begin
        o_push      = acc;
        o_item.fmt  = t_fmt'(r_fmt);
        o_item.data = i_in_byte;
        o_item.held = r_held;
        o_item.boff = boff;
        o_item.bx   = wide_x ? {r_tcol, 3'b0} : {1'b0, r_tcol, 2'b0};
        o_item.by   = tall_y ? {r_trow, 3'b0} : {1'b0, r_trow, 2'b0};
        o_item.done = img_end;
    end

    // Advance position, hold config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_I4; r_w <= 11'd8; r_h <= 11'd8;
            r_tcol <= '0; r_trow <= '0; r_boff <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FMT:    r_fmt <= i_cfg_data[2:0];
                REG_WIDTH:  r_w <= i_cfg_data;
                REG_HEIGHT: r_h <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index <= REG_HEIGHT) begin
                r_tcol <= '0; r_trow <= '0; r_boff <= '0;
            end
        end else if (acc) begin
            if (tile_end) begin
                r_boff <= '0;
                if (row_end) begin
                    r_tcol <= '0;
                    r_trow <= (n_trow >= tiles_y) ? '0 : n_trow[9:0];
                end else begin
                    r_tcol <= n_tcol[9:0];
                end
            end else begin
                r_boff <= boff + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !boff[0]) r_held <= i_in_byte;
    end
endmodule

>>> src/ttd_fifo.sv
`timescale 1ns / 1ps
module ttd_fifo import ttd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);
    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_mem[r_rp];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule

>>> src/ttd_back.sv
`timescale 1ns / 1ps
module ttd_back import ttd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_w,
    input  logic [10:0] i_h,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_pix_x,
    output logic [9:0]  o_pix_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_of_item,
    output logic        o_image_done
);
    logic [15:0] r_ar [16];
    logic [15:0] r_c0, r_c1;
    logic [1:0]  r_sub;
    logic [12:0] w_c, h_c;
    logic [12:0] px [4];
    logic [12:0] py;
    logic [7:0]  pr [4], pg [4], pb [4], pa [4];
    logic [2:0]  cnt;
    logic [3:0]  vis, rem, rest;
    logic [15:0] pxw;
    logic [3:0]  p;
    logic [7:0]  e0 [3], e1 [3];
    logic [9:0]  s2 [3], s1 [3];
    logic [7:0]  m2 [3], m1 [3], mh [3];
    logic        cgt, load, fire;
    logic [1:0]  sel;
    logic [1:0]  idx;

    always_comb begin
        if (i_w == '0) w_c = 13'd1;
        else if ({2'b0, i_w} > 13'(MAX_WIDTH)) w_c = 13'(MAX_WIDTH);
        else w_c = {2'b0, i_w};
        if (i_h == '0) h_c = 13'd1;
        else if ({2'b0, i_h} > 13'(MAX_HEIGHT)) h_c = 13'(MAX_HEIGHT);
        else h_c = {2'b0, i_h};
    end

    // CMPR palette from stored endpoints
    assign cgt = r_c0 > r_c1;
    always_comb begin
        e0[0] = sc5(r_c0[15:11]); e0[1] = sc6(r_c0[10:5]); e0[2] = sc5(r_c0[4:0]);
        e1[0] = sc5(r_c1[15:11]); e1[1] = sc6(r_c1[10:5]); e1[2] = sc5(r_c1[4:0]);
        for (int c = 0; c < 3; c++) begin
            s2[c] = {1'b0, e0[c], 1'b0} + {2'b0, e1[c]};
            s1[c] = {2'b0, e0[c]} + {1'b0, e1[c], 1'b0};
            m2[c] = 8'((19'(s2[c]) * 19'd683) >> 11);
            m1[c] = 8'((19'(s1[c]) * 19'd683) >> 11);
            mh[c] = 8'(({1'b0, e0[c]} + {1'b0, e1[c]}) >> 1);
        end
    end

    // Expand the head item into up to four texels
    always_comb begin
        pxw = {i_item.held, i_item.data};
        p   = i_item.boff[4:1];
        py  = '0;
        sel = '0;
        idx = '0;
        for (int k = 0; k < 4; k++) begin
            px[k] = '0; pr[k] = '0; pg[k] = '0; pb[k] = '0; pa[k] = 8'hFF;
        end
        cnt = 3'd0;
        unique case (i_item.fmt)
            FMT_I4: begin
                cnt = 3'd2;
                py  = i_item.by + 13'(i_item.boff[5:2]);
                px[0] = i_item.bx + {10'd0, i_item.boff[1:0], 1'b0};
                px[1] = px[0] + 13'd1;
                pr[0] = sc4(i_item.data[7:4]); pr[1] = sc4(i_item.data[3:0]);
                pg[0] = pr[0]; pb[0] = pr[0]; pg[1] = pr[1]; pb[1] = pr[1];
            end
            FMT_I8, FMT_IA4: begin
                cnt = 3'd1;
                py  = i_item.by + 13'(i_item.boff[5:3]);
                px[0] = i_item.bx + 13'(i_item.boff[2:0]);
                if (i_item.fmt == FMT_I8) begin
                    pr[0] = i_item.data;
                end else begin
                    pr[0] = sc4(i_item.data[3:0]); pa[0] = sc4(i_item.data[7:4]);
                end
                pg[0] = pr[0]; pb[0] = pr[0];
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8: begin
                cnt = i_item.boff[0] ? 3'd1 : 3'd0;
                if (i_item.fmt == FMT_RGBA8 && !i_item.boff[5]) cnt = 3'd0;
                py  = i_item.by + 13'(p[3:2]);
                px[0] = i_item.bx + 13'(p[1:0]);
                if (i_item.fmt == FMT_IA8) begin
                    pr[0] = i_item.data; pg[0] = i_item.data; pb[0] = i_item.data;
                    pa[0] = i_item.held;
                end else if (i_item.fmt == FMT_RGB565) begin
                    pr[0] = sc5(pxw[15:11]); pg[0] = sc6(pxw[10:5]); pb[0] = sc5(pxw[4:0]);
                end else if (i_item.fmt == FMT_RGB5A3) begin
                    if (pxw[15]) begin
                        pr[0] = sc5(pxw[14:10]); pg[0] = sc5(pxw[9:5]);
                        pb[0] = sc5(pxw[4:0]);
                    end else begin
                        pr[0] = sc4(pxw[11:8]); pg[0] = sc4(pxw[7:4]);
                        pb[0] = sc4(pxw[3:0]); pa[0] = sc3(pxw[14:12]);
                    end
                end else begin
                    pr[0] = r_ar[p][7:0]; pg[0] = i_item.held; pb[0] = i_item.data;
                    pa[0] = r_ar[p][15:8];
                end
            end
            default: begin
                cnt = i_item.boff[2] ? 3'd4 : 3'd0;
                py  = i_item.by + {10'd0, i_item.boff[4], i_item.boff[1:0]};
                for (int k = 0; k < 4; k++) begin
                    px[k] = i_item.bx + {10'd0, i_item.boff[3], 2'(k)};
                    sel = 2'(i_item.data >> (6 - 2 * k));
                    for (int c = 0; c < 3; c++) begin
                        unique case (sel)
                            2'd0: idx = 2'd0;
                            default: idx = sel;
                        endcase
                    end
                    unique case (idx)
                        2'd0: begin pr[k] = e0[0]; pg[k] = e0[1]; pb[k] = e0[2]; end
                        2'd1: begin pr[k] = e1[0]; pg[k] = e1[1]; pb[k] = e1[2]; end
                        2'd2: begin
                            pr[k] = cgt ? m2[0] : mh[0];
                            pg[k] = cgt ? m2[1] : mh[1];
                            pb[k] = cgt ? m2[2] : mh[2];
                        end
                        default: begin
                            pr[k] = cgt ? m1[0] : 8'd0;
                            pg[k] = cgt ? m1[1] : 8'd0;
                            pb[k] = cgt ? m1[2] : 8'd0;
                            pa[k] = cgt ? 8'hFF : 8'd0;
                        end
                    endcase
                end
            end
        endcase
        for (int k = 0; k < 4; k++)
            vis[k] = (3'(k) < cnt) && (px[k] < w_c) && (py < h_c);
    end

    // Texels of the head item still to emit
    assign rem  = vis & ~{r_sub > 2'd3, r_sub > 2'd2, r_sub > 2'd1, r_sub > 2'd0};
    logic [1:0] first;
    always_comb begin
        first = 2'd0;
        priority if (rem[0]) first = 2'd0;
        else if (rem[1]) first = 2'd1;
        else if (rem[2]) first = 2'd2;
        else first = 2'd3;
        rest = rem & ~(4'd1 << first);
    end

    assign load  = !o_valid || i_ready;
    assign fire  = i_valid && load;
    assign o_pop = i_valid && load && (rest == '0);

    // Output register and sub-texel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0; r_sub <= '0;
        end else if (load) begin
            o_valid <= fire && (rem != '0);
            if (fire) r_sub <= (rest == '0) ? 2'd0 : first + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_pix_x <= px[first][9:0]; o_pix_y <= py[9:0];
            o_red <= pr[first]; o_green <= pg[first]; o_blue <= pb[first];
            o_alpha <= pa[first];
            o_last_of_item <= rest == '0;
            o_image_done <= i_item.done;
        end
    end

    // Capture RGBA8 AR half and CMPR endpoints
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.boff[0]) begin
            if (i_item.fmt == FMT_RGBA8 && !i_item.boff[5]) r_ar[p] <= pxw;
            if (i_item.fmt == FMT_CMPR && !i_item.boff[2]) begin
                if (i_item.boff[1]) r_c1 <= pxw;
                else r_c0 <= pxw;
            end
        end
    end
endmodule

>>> src/tiled_texture_decoder.sv
`timescale 1ns / 1ps
// Tiled texture decoder: bytes in stored order, RGBA8888 texels with x/y out
// in tile order. A byte leaves zero to four texels, one per cycle from the
// output register while the consumer is ready (I4 two, CMPR index row four);
// the expansion stage sets how many. A four-deep queue decouples the byte
// counter from the texel stage.
`include "assert_macros.svh"
module tiled_texture_decoder import ttd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_pix_x,
    output logic [9:0]  o_pix_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_of_item,
    output logic        o_image_done
);
    t_item       f_item, q_item;
    logic        push, full, q_valid, pop;
    logic [10:0] r_w, r_h;

    ttd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_ready, .i_in_byte, .o_push(push), .o_item(f_item),
        .i_full(full)
    );

    ttd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_item(f_item), .o_full(full),
        .o_valid(q_valid), .o_item(q_item), .i_pop(pop)
    );

    // Track dimensions for the visibility test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd8; r_h <= 11'd8;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH) r_w <= i_cfg_data;
            if (i_cfg_index == REG_HEIGHT) r_h <= i_cfg_data;
        end
    end

    ttd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk, .i_rst_n, .i_w(r_w), .i_h(r_h), .i_valid(q_valid),
        .i_item(q_item), .o_pop(pop), .o_valid, .i_ready, .o_pix_x, .o_pix_y,
        .o_red, .o_green, .o_blue, .o_alpha, .o_last_of_item, .o_image_done
    );

    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, push && full)
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, pop && !q_valid)
    `ASSERT_IMPL(a_hold_stall, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
endmodule
